/* rtl/bmw_pkg.sv */
// Shared types and codes for the backtracker maze walker.
package bmw_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] EV_CARVE = 2'd0;
  localparam logic [1:0] EV_BACK  = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;
  localparam logic [1:0] EV_START = 2'd3;

  localparam logic [1:0] SIDE_LEFT  = 2'd0;
  localparam logic [1:0] SIDE_UP    = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;
  localparam logic [1:0] SIDE_DOWN  = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] pick;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [5:0] from_x;
    logic [5:0] from_y;
    logic [1:0] wall_side;
    logic [5:0] at_x;
    logic [5:0] at_y;
    logic       done_res;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RD_DN,
    S_RD_CUR,
    S_PICK,
    S_POP,
    S_EMIT
  } state_t;

endpackage

/* rtl/backtracker_maze_walker_unit.sv */
// Top level of the depth-first maze walker: visited-row memory, path stack and control.

// Depth-first maze carver. The visited map lives in a single-port memory of MAX_ROWS
// words, one MAX_COLS-bit row per word; the path stack lives in a single-port memory of
// MAX_ROWS*MAX_COLS cell coordinates. A walk step that carves is accepted, then the rows
// above, below and of the current cell are read one after another through the
// visited-row port, and the new row bit is written back. A backtrack adds a path stack
// read. A step after the walk has finished is answered from the idle state. A start
// item sweeps the whole visited memory, one row per cycle. One result per item is held
// in an output register; a second result stalls the block only while that register is
// still full.
module backtracker_maze_walker_unit #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bmw_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bmw_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [bmw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bmw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int SAW = $clog2(CELL_COUNT);
  localparam int SDW = $clog2(CELL_COUNT + 1);
  localparam int CLW = SAW;
  localparam int CMPW = ((CW > bmw_pkg::CFG_DATA_W) ? CW : bmw_pkg::CFG_DATA_W) + 1;
  localparam int RCMPW = ((RW > bmw_pkg::CFG_DATA_W) ? RW : bmw_pkg::CFG_DATA_W) + 1;
  localparam int TW = 2 * bmw_pkg::CFG_DATA_W;

  // pick mod 3: base-4 digits sum to the same residue
  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd6) begin
      mod3 = 2'(t - 3'd6);
    end else if (t >= 3'd3) begin
      mod3 = 2'(t - 3'd3);
    end else begin
      mod3 = t[1:0];
    end
  endfunction

  bmw_pkg::state_t state_r, state_nxt;

  logic [bmw_pkg::CFG_DATA_W-1:0] rows_r, cols_r;
  logic [CW-1:0]  cur_x_r, cur_x_nxt;
  logic [RW-1:0]  cur_y_r, cur_y_nxt;
  logic [SDW-1:0] depth_r, depth_nxt;
  logic [CLW-1:0] left_r, left_nxt;
  logic           finished_r, finished_nxt;
  logic [RW-1:0]  cnt_r, cnt_nxt;
  logic [7:0]     pick_r, pick_nxt;
  logic [MAX_COLS-1:0] up_r, up_nxt, dn_r, dn_nxt;

  bmw_pkg::out_item_t out_r, hold_r, res_c;
  logic out_valid_r;
  logic out_free;
  logic res_load;

  // visited-row memory
  logic [MAX_COLS-1:0] vm_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] vm_q_r, vm_wdata;
  logic                vm_re, vm_we;
  logic [RW-1:0]       vm_raddr, vm_waddr;

  // path stack memory
  logic [RW+CW-1:0] st_mem [CELL_COUNT];
  logic [RW+CW-1:0] st_q_r, st_wdata;
  logic             st_re, st_we;
  logic [SAW-1:0]   st_addr;

  // effective grid size and cell total
  logic [bmw_pkg::CFG_DATA_W-1:0] eff_rows, eff_cols;
  logic [TW-1:0] total;

  assign eff_rows = (int'(rows_r) > MAX_ROWS) ? bmw_pkg::CFG_DATA_W'(MAX_ROWS) : rows_r;
  assign eff_cols = (int'(cols_r) > MAX_COLS) ? bmw_pkg::CFG_DATA_W'(MAX_COLS) : cols_r;
  assign total = TW'(eff_rows) * TW'(eff_cols);

  // neighbor candidates of the current cell
  logic [3:0] free_v;
  logic [2:0] n_free;
  logic [1:0] k_sel, side_sel;
  logic [CW-1:0] cxm1, cxp1, nx;
  logic [RW-1:0] cym1, cyp1, ny;
  logic right_ok, down_ok;

  assign cxm1 = CW'(cur_x_r - 1'b1);
  assign cxp1 = CW'(cur_x_r + 1'b1);
  assign cym1 = RW'(cur_y_r - 1'b1);
  assign cyp1 = RW'(cur_y_r + 1'b1);
  assign right_ok = (CMPW'(cur_x_r) + CMPW'(1)) < CMPW'(eff_cols);
  assign down_ok  = (RCMPW'(cur_y_r) + RCMPW'(1)) < RCMPW'(eff_rows);

  always_comb begin
    free_v[0] = (cur_x_r != '0) ? !vm_q_r[cxm1] : 1'b0;
    free_v[1] = (cur_y_r != '0) ? !up_r[cur_x_r] : 1'b0;
    free_v[2] = right_ok ? !vm_q_r[cxp1] : 1'b0;
    free_v[3] = down_ok ? !dn_r[cur_x_r] : 1'b0;
    n_free = 3'(free_v[0]) + 3'(free_v[1]) + 3'(free_v[2]) + 3'(free_v[3]);
  end

  always_comb begin
    case (n_free)
      3'd2:    k_sel = {1'b0, pick_r[0]};
      3'd3:    k_sel = mod3(pick_r);
      3'd4:    k_sel = pick_r[1:0];
      default: k_sel = 2'd0;
    endcase
  end

  always_comb begin
    logic [2:0] seen;
    seen = 3'd0;
    side_sel = bmw_pkg::SIDE_LEFT;
    for (int i = 0; i < 4; i++) begin
      if (free_v[i]) begin
        if (seen == 3'(k_sel)) begin
          side_sel = 2'(i);
        end
        seen = seen + 3'd1;
      end
    end
  end

  always_comb begin
    nx = cur_x_r;
    ny = cur_y_r;
    case (side_sel)
      bmw_pkg::SIDE_LEFT:  nx = cxm1;
      bmw_pkg::SIDE_UP:    ny = cym1;
      bmw_pkg::SIDE_RIGHT: nx = cxp1;
      bmw_pkg::SIDE_DOWN:  ny = cyp1;
      default:             nx = cur_x_r;
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  // next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    depth_nxt    = depth_r;
    left_nxt     = left_r;
    finished_nxt = finished_r;
    cnt_nxt      = cnt_r;
    pick_nxt     = pick_r;
    up_nxt       = up_r;
    dn_nxt       = dn_r;
    in_ready     = 1'b0;
    vm_re        = 1'b0;
    vm_raddr     = cur_y_r;
    vm_we        = 1'b0;
    vm_waddr     = cnt_r;
    vm_wdata     = '0;
    st_re        = 1'b0;
    st_we        = 1'b0;
    st_addr      = depth_r[SAW-1:0];
    st_wdata     = {cur_y_r, cur_x_r};
    res_load     = 1'b0;
    res_c        = '0;

    case (state_r)
      bmw_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.op == bmw_pkg::OP_START) begin
            depth_nxt = '0;
            cur_x_nxt = '0;
            cur_y_nxt = '0;
            cnt_nxt   = RW'(MAX_ROWS - 1);
            if (total <= TW'(1)) begin
              left_nxt     = '0;
              finished_nxt = 1'b1;
            end else begin
              left_nxt     = CLW'(total - TW'(1));
              finished_nxt = 1'b0;
            end
            state_nxt = bmw_pkg::S_CLEAR;
          end else if (finished_r) begin
            res_load        = 1'b1;
            res_c.event_res = bmw_pkg::EV_DONE;
            res_c.at_x      = 6'(cur_x_r);
            res_c.at_y      = 6'(cur_y_r);
            res_c.done_res  = 1'b1;
          end else begin
            vm_re     = 1'b1;
            vm_raddr  = cym1;
            pick_nxt  = in_data.pick;
            state_nxt = bmw_pkg::S_RD_DN;
          end
        end
      end

      // sweep rows bottom up; row 0 comes last and gets the start cell marked
      bmw_pkg::S_CLEAR: begin
        vm_we    = 1'b1;
        vm_waddr = cnt_r;
        if (cnt_r == '0) begin
          vm_wdata        = MAX_COLS'(1);
          res_load        = 1'b1;
          res_c.event_res = finished_r ? bmw_pkg::EV_DONE : bmw_pkg::EV_START;
          res_c.done_res  = finished_r;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      bmw_pkg::S_RD_DN: begin
        vm_re     = 1'b1;
        vm_raddr  = cyp1;
        up_nxt    = vm_q_r;
        state_nxt = bmw_pkg::S_RD_CUR;
      end

      bmw_pkg::S_RD_CUR: begin
        vm_re     = 1'b1;
        vm_raddr  = cur_y_r;
        dn_nxt    = vm_q_r;
        state_nxt = bmw_pkg::S_PICK;
      end

      bmw_pkg::S_PICK: begin
        if (n_free != 3'd0) begin
          vm_we    = 1'b1;
          vm_waddr = ny;
          case (side_sel)
            bmw_pkg::SIDE_UP:   vm_wdata = up_r | (MAX_COLS'(1) << nx);
            bmw_pkg::SIDE_DOWN: vm_wdata = dn_r | (MAX_COLS'(1) << nx);
            default:            vm_wdata = vm_q_r | (MAX_COLS'(1) << nx);
          endcase
          if (depth_r < SDW'(CELL_COUNT)) begin
            st_we     = 1'b1;
            depth_nxt = depth_r + 1'b1;
          end
          if (left_r != '0) begin
            left_nxt = left_r - 1'b1;
          end
          if (left_nxt == '0) begin
            finished_nxt = 1'b1;
          end
          cur_x_nxt       = nx;
          cur_y_nxt       = ny;
          res_load        = 1'b1;
          res_c.event_res = bmw_pkg::EV_CARVE;
          res_c.from_x    = 6'(cur_x_r);
          res_c.from_y    = 6'(cur_y_r);
          res_c.wall_side = side_sel;
          res_c.at_x      = 6'(nx);
          res_c.at_y      = 6'(ny);
          res_c.done_res  = finished_nxt;
        end else if (depth_r != '0) begin
          st_re     = 1'b1;
          st_addr   = SAW'(depth_r - 1'b1);
          depth_nxt = depth_r - 1'b1;
          state_nxt = bmw_pkg::S_POP;
        end else begin
          finished_nxt    = 1'b1;
          res_load        = 1'b1;
          res_c.event_res = bmw_pkg::EV_DONE;
          res_c.at_x      = 6'(cur_x_r);
          res_c.at_y      = 6'(cur_y_r);
          res_c.done_res  = 1'b1;
        end
      end

      bmw_pkg::S_POP: begin
        cur_x_nxt       = st_q_r[CW-1:0];
        cur_y_nxt       = st_q_r[RW+CW-1:CW];
        res_load        = 1'b1;
        res_c.event_res = bmw_pkg::EV_BACK;
        res_c.from_x    = 6'(cur_x_r);
        res_c.from_y    = 6'(cur_y_r);
        res_c.at_x      = 6'(st_q_r[CW-1:0]);
        res_c.at_y      = 6'(st_q_r[RW+CW-1:CW]);
      end

      bmw_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = bmw_pkg::S_IDLE;
        end
      end

      default: state_nxt = bmw_pkg::S_IDLE;
    endcase

    if (res_load) begin
      state_nxt = out_free ? bmw_pkg::S_IDLE : bmw_pkg::S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bmw_pkg::S_IDLE;
      rows_r     <= bmw_pkg::CFG_DATA_W'(16);
      cols_r     <= bmw_pkg::CFG_DATA_W'(16);
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      depth_r    <= '0;
      left_r     <= '0;
      finished_r <= 1'b1;
      cnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      depth_r    <= depth_nxt;
      left_r     <= left_nxt;
      finished_r <= finished_nxt;
      cnt_r      <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          bmw_pkg::CFG_ROWS: rows_r <= cfg_wdata;
          bmw_pkg::CFG_COLS: cols_r <= cfg_wdata;
          default: ;
        endcase
      end
      if ((res_load || state_r == bmw_pkg::S_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pick_r <= pick_nxt;
    up_r   <= up_nxt;
    dn_r   <= dn_nxt;
    if (res_load && out_free) begin
      out_r <= res_c;
    end else if (state_r == bmw_pkg::S_EMIT && out_free) begin
      out_r <= hold_r;
    end
    if (res_load && !out_free) begin
      hold_r <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vm_mem[vm_waddr] <= vm_wdata;
    end
    if (vm_re) begin
      vm_q_r <= vm_mem[vm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_addr] <= st_wdata;
    end
    if (st_re) begin
      st_q_r <= st_mem[st_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a held result always means the output register was occupied
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bmw_pkg::S_EMIT |-> out_valid_r)
    else $error("emit wait with empty output register");

  a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bmw_pkg::S_POP |-> $past(depth_r) == depth_r + 1'b1)
    else $error("stack depth not decremented on pop");

  a_walk_left: assert property (@(posedge clk) disable iff (!rst_n)
    !finished_r |-> left_r != '0)
    else $error("walk active with no cells left");

  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= SDW'(CELL_COUNT))
    else $error("stack depth overflow");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the depth-first maze walker: predictor, scoreboard and drivers.
module testbench;

  localparam int GRID_MAX_R = 64;
  localparam int GRID_MAX_C = 64;
  localparam int GRID_CELLS = GRID_MAX_R * GRID_MAX_C;
  localparam int RAND_ITEMS = 450;
  localparam int CALM_ITEMS = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_MAX = 10;

  // Carver predictor plus the queue of events it expects from the block.
  class carve_tracker;
    bit visited[GRID_CELLS];
    int trail[GRID_CELLS];
    int trail_depth;
    int cur;
    int left;
    bit finished;
    logic [6:0] rows_reg;
    logic [6:0] cols_reg;
    bmw_pkg::out_item_t expected_events[$];
    int fails;

    function new();
      visited = '{default: 1'b0};
      trail_depth = 0;
      cur = 0;
      left = 0;
      finished = 1'b1;
      rows_reg = 7'd16;
      cols_reg = 7'd16;
      fails = 0;
    endfunction

    function void write_reg(logic [bmw_pkg::CFG_IDX_W-1:0] idx,
                            logic [bmw_pkg::CFG_DATA_W-1:0] val);
      if (idx == bmw_pkg::CFG_ROWS) rows_reg = val;
      else if (idx == bmw_pkg::CFG_COLS) cols_reg = val;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void note_item(bmw_pkg::in_item_t it);
      bmw_pkg::out_item_t r;
      int nr, nc, cx, cy, n, k, nxt;
      int cand[4];
      logic [1:0] dir[4];
      nr = (rows_reg > GRID_MAX_R) ? GRID_MAX_R : int'(rows_reg);
      nc = (cols_reg > GRID_MAX_C) ? GRID_MAX_C : int'(cols_reg);
      cx = cur % GRID_MAX_C;
      cy = cur / GRID_MAX_C;
      r = '0;
      if (it.op == bmw_pkg::OP_START) begin
        visited = '{default: 1'b0};
        trail_depth = 0;
        cur = 0;
        visited[0] = 1'b1;
        if (nr * nc <= 1) begin
          left = 0;
          finished = 1'b1;
          r.event_res = bmw_pkg::EV_DONE;
          r.done_res = 1'b1;
        end else begin
          left = nr * nc - 1;
          finished = 1'b0;
          r.event_res = bmw_pkg::EV_START;
        end
      end else if (finished) begin
        r.event_res = bmw_pkg::EV_DONE;
        r.at_x = 6'(cx);
        r.at_y = 6'(cy);
        r.done_res = 1'b1;
      end else begin
        n = 0;
        if (cx > 0 && !visited[cur - 1]) begin
          cand[n] = cur - 1; dir[n] = bmw_pkg::SIDE_LEFT; n++;
        end
        if (cy > 0 && !visited[cur - GRID_MAX_C]) begin
          cand[n] = cur - GRID_MAX_C; dir[n] = bmw_pkg::SIDE_UP; n++;
        end
        if (cx + 1 < nc && !visited[cur + 1]) begin
          cand[n] = cur + 1; dir[n] = bmw_pkg::SIDE_RIGHT; n++;
        end
        if (cy + 1 < nr && !visited[cur + GRID_MAX_C]) begin
          cand[n] = cur + GRID_MAX_C; dir[n] = bmw_pkg::SIDE_DOWN; n++;
        end
        if (n > 0) begin
          k = int'(it.pick) % n;
          nxt = cand[k];
          if (trail_depth < GRID_CELLS) begin
            trail[trail_depth] = cur;
            trail_depth++;
          end
          cur = nxt;
          visited[nxt] = 1'b1;
          if (left > 0) left--;
          if (left == 0) finished = 1'b1;
          r.event_res = bmw_pkg::EV_CARVE;
          r.from_x = 6'(cx);
          r.from_y = 6'(cy);
          r.wall_side = dir[k];
          r.at_x = 6'(nxt % GRID_MAX_C);
          r.at_y = 6'(nxt / GRID_MAX_C);
          r.done_res = finished;
        end else if (trail_depth > 0) begin
          trail_depth--;
          cur = trail[trail_depth] % GRID_CELLS;
          r.event_res = bmw_pkg::EV_BACK;
          r.from_x = 6'(cx);
          r.from_y = 6'(cy);
          r.at_x = 6'(cur % GRID_MAX_C);
          r.at_y = 6'(cur / GRID_MAX_C);
        end else begin
          // dead end with an empty path: walk is over
          finished = 1'b1;
          r.event_res = bmw_pkg::EV_DONE;
          r.at_x = 6'(cx);
          r.at_y = 6'(cy);
          r.done_res = 1'b1;
        end
      end
      expected_events.insert(expected_events.size(), r);
    endfunction

    function void check_event(bmw_pkg::out_item_t got);
      bmw_pkg::out_item_t want;
      bit bad;
      if (expected_events.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("unexpected event: ev=%0d from=(%0d,%0d) side=%0d at=(%0d,%0d) done=%0d",
                   got.event_res, got.from_x, got.from_y, got.wall_side,
                   got.at_x, got.at_y, got.done_res);
        return;
      end
      want = expected_events.pop_front();
      bad = (got.event_res !== want.event_res) || (got.from_x !== want.from_x) ||
            (got.from_y !== want.from_y) || (got.wall_side !== want.wall_side) ||
            (got.at_x !== want.at_x) || (got.at_y !== want.at_y) ||
            (got.done_res !== want.done_res);
      if (bad) begin
        fails++;
        if (fails <= REPORT_MAX) begin
          $display("event mismatch: exp ev=%0d from=(%0d,%0d) side=%0d at=(%0d,%0d) done=%0d",
                   want.event_res, want.from_x, want.from_y, want.wall_side,
                   want.at_x, want.at_y, want.done_res);
          $display("                got ev=%0d from=(%0d,%0d) side=%0d at=(%0d,%0d) done=%0d",
                   got.event_res, got.from_x, got.from_y, got.wall_side,
                   got.at_x, got.at_y, got.done_res);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  bmw_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  bmw_pkg::out_item_t out_data;
  logic cfg_we;
  logic [bmw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bmw_pkg::CFG_DATA_W-1:0] cfg_wdata;

  carve_tracker board;
  int idle_cycles = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  backtracker_maze_walker_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sample every transfer at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) board.note_item(in_data);
      if (out_valid && out_ready) board.check_event(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin : receiver
    int stall_left;
    logic ready_next;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        ready_next = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("testbench: errors");
    $finish;
  end

  function automatic bmw_pkg::in_item_t step_item(int pick);
    bmw_pkg::in_item_t it;
    it.op = bmw_pkg::OP_STEP;
    it.pick = 8'(pick);
    return it;
  endfunction

  function automatic bmw_pkg::in_item_t start_item();
    bmw_pkg::in_item_t it;
    it.op = bmw_pkg::OP_START;
    it.pick = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send(input bmw_pkg::in_item_t it);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // drop valid and wait for every expected event, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_grid(input int rows, input int cols);
    cfg_we <= 1'b1;
    cfg_index <= bmw_pkg::CFG_ROWS;
    cfg_wdata <= 7'(rows);
    @(negedge clk);
    cfg_index <= bmw_pkg::CFG_COLS;
    cfg_wdata <= 7'(cols);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int rows, cols, er, ec, steps, sel, phase;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = bmw_pkg::CFG_ROWS;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // step straight out of reset: already finished at the origin
    send(step_item(0));
    settle();

    // oversized registers saturate to the full grid
    set_grid(127, 127);
    send(start_item());
    send(step_item(0));
    send(step_item(255));
    send(step_item(128));
    settle();

    // single cell and empty grids finish at once
    set_grid(1, 1);
    send(start_item());
    send(step_item(77));
    settle();
    set_grid(0, 64);
    send(start_item());
    settle();

    // last cell carved carries done
    set_grid(1, 2);
    send(start_item());
    send(step_item(255));
    send(step_item(3));
    settle();

    // shrink the grid mid-walk: backtrack, then empty-path finish
    set_grid(2, 2);
    send(start_item());
    send(step_item(0));
    settle();
    set_grid(1, 1);
    send(step_item(1));
    send(step_item(2));
    send(step_item(200));
    settle();

    set_grid(3, 3);
    send(start_item());
    for (int i = 0; i < 8; i++) send(step_item(i * 37));
    settle();

    items_sent = 0;
    phase = 0;
    while (items_sent < RAND_ITEMS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: begin
          rows = $urandom_range(0, 127);
          cols = $urandom_range(0, 127);
        end
        1: begin
          rows = ($urandom_range(0, 1) != 0) ? 64 : 127;
          cols = ($urandom_range(0, 1) != 0) ? 64 : 127;
        end
        2: begin
          rows = 1;
          cols = $urandom_range(1, 8);
        end
        3: begin
          rows = $urandom_range(1, 8);
          cols = 1;
        end
        default: begin
          rows = $urandom_range(2, 6);
          cols = $urandom_range(2, 6);
        end
      endcase
      set_grid(rows, cols);
      if (items_sent >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      // fill the block up against a stalled result side once
      if (phase == 2) hold_req = 1'b1;
      er = (rows > GRID_MAX_R) ? GRID_MAX_R : rows;
      ec = (cols > GRID_MAX_C) ? GRID_MAX_C : cols;
      steps = 2 * er * ec + 3;
      if (steps > 70) steps = 70;
      if (steps > RAND_ITEMS - items_sent - 1) steps = RAND_ITEMS - items_sent - 1;
      send(start_item());
      for (int i = 0; i < steps; i++) begin
        if ($urandom_range(0, 19) == 0) send(start_item());
        else send(step_item($urandom_range(0, 255)));
      end
      settle();
      phase++;
    end

    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    board.fails += board.pending();
    if (board.fails == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
